/* rtl/core/hsl2rgb_pkg.sv */
// Shared types and constants for the HSL to RGB color converter.
package hsl2rgb_pkg;

    // Width of every color channel and of hue.
    localparam int CH_BITS = 16;

    // One full hue turn and the largest channel value.
    localparam int TURN   = 1 << CH_BITS;
    localparam int CH_MAX = TURN - 1;

    // Hue positions are measured in thirds of a turn, so they span three turns.
    localparam int POS_BITS = CH_BITS + 2;

    typedef logic [CH_BITS-1:0]  chan_t;
    typedef logic [POS_BITS-1:0] pos_t;

    // Breakpoints of the piecewise-linear hue rule, in position units.
    localparam pos_t POS_HALF_TURN   = pos_t'(TURN / 2);
    localparam pos_t POS_THREE_HALF  = pos_t'((3 * TURN) / 2);
    localparam pos_t POS_TWO_TURN    = pos_t'(2 * TURN);

    // Channel order inside the position array.
    localparam int IDX_RED   = 0;
    localparam int IDX_GREEN = 1;
    localparam int IDX_BLUE  = 2;

    typedef struct packed {
        chan_t hue;
        chan_t saturation;
        chan_t lightness;
    } hsl_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } rgb_t;

    // Per-request side data that rides along the level pipeline.
    typedef struct packed {
        logic            grey;
        chan_t           light;
        pos_t [2:0]      pos;
    } carry_t;

    // Result of the level pipeline: the upper and lower levels plus side data.
    typedef struct packed {
        carry_t info;
        chan_t  qc;
        chan_t  pc;
    } level_t;

endpackage

/* rtl/core/hsl2rgb_levels.sv */
// Five-stage pipeline that forms the upper and lower color levels and hue positions.
module hsl2rgb_levels
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                pix_valid,
    input  hsl2rgb_pkg::hsl_t   pix,
    output logic                lvl_valid,
    output hsl2rgb_pkg::level_t lvl
);

    localparam int N  = hsl2rgb_pkg::CH_BITS;
    localparam int WB = 2 * N + 2;

    typedef logic [WB-1:0]  wide_t;
    typedef logic [N+2:0]   ext_pos_t;

    localparam ext_pos_t EXT_TURN       = ext_pos_t'(hsl2rgb_pkg::TURN);
    localparam ext_pos_t EXT_THREE_TURN = ext_pos_t'(3 * hsl2rgb_pkg::TURN);
    localparam wide_t    W_MAX          = wide_t'(hsl2rgb_pkg::CH_MAX);
    localparam wide_t    W_HALF_MAX     = wide_t'((hsl2rgb_pkg::CH_MAX - 1) / 2);

    logic [4:0] valid_reg;

    // Stage 1 registers.
    hsl2rgb_pkg::carry_t   info1_reg;
    hsl2rgb_pkg::chan_t    sat1_reg;
    logic                  low1_reg;
    logic [2*N-1:0]        ls1_reg;
    // Stage 2 registers.
    hsl2rgb_pkg::carry_t   info2_reg;
    logic [2*N-1:0]        y2_reg;
    // Stage 3 registers.
    hsl2rgb_pkg::carry_t   info3_reg;
    logic [2*N-1:0]        y3_reg;
    logic [N:0]            q3_reg;
    // Stage 4 registers.
    hsl2rgb_pkg::carry_t   info4_reg;
    logic [N:0]            q4_reg;
    // Stage 5 registers.
    hsl2rgb_pkg::level_t   lvl5_reg;

    hsl2rgb_pkg::carry_t   info1_next;
    logic                  low1_next;
    logic [2*N-1:0]        ls1_next;
    ext_pos_t              u_ext;
    ext_pos_t              ur_sum;
    ext_pos_t              ub_sum;
    logic [2*N-1:0]        y2_next;
    wide_t                 lm;
    wide_t                 sm;
    wide_t                 qn;
    logic [2*N:0]          est_sum;
    logic [N:0]            q3_next;
    wide_t                 rem;
    logic [N:0]            q4_next;
    logic [N:0]            two_l;
    logic [N:0]            q_clamp;
    logic [N:0]            p_raw;
    hsl2rgb_pkg::level_t   lvl5_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[3:0], pix_valid};
        end
    end

    // Stage 1: the one multiplier, hue positions for the three channels.
    always_comb
    begin
        u_ext  = ext_pos_t'({pix.hue, 1'b0}) + ext_pos_t'(pix.hue);
        ur_sum = u_ext + EXT_TURN;
        if (ur_sum >= EXT_THREE_TURN)
        begin
            ur_sum = ur_sum - EXT_THREE_TURN;
        end
        ub_sum = u_ext + (EXT_TURN << 1);
        if (ub_sum >= EXT_THREE_TURN)
        begin
            ub_sum = ub_sum - EXT_THREE_TURN;
        end
        info1_next.grey  = (pix.saturation == '0);
        info1_next.light = pix.lightness;
        info1_next.pos[hsl2rgb_pkg::IDX_RED]   = hsl2rgb_pkg::pos_t'(ur_sum);
        info1_next.pos[hsl2rgb_pkg::IDX_GREEN] = hsl2rgb_pkg::pos_t'(u_ext);
        info1_next.pos[hsl2rgb_pkg::IDX_BLUE]  = hsl2rgb_pkg::pos_t'(ub_sum);
        low1_next = ({pix.lightness, 1'b0} < (N+1)'(hsl2rgb_pkg::CH_MAX));
        ls1_next  = {{N{1'b0}}, pix.lightness} * {{N{1'b0}}, pix.saturation};
    end

    // Stage 2: the upper level scaled by M, plus the rounding offset.
    always_comb
    begin
        lm = (wide_t'(info1_reg.light) << N) - wide_t'(info1_reg.light);
        sm = (wide_t'(sat1_reg) << N) - wide_t'(sat1_reg);
        if (low1_reg)
        begin
            qn = lm + wide_t'(ls1_reg);
        end
        else
        begin
            qn = lm - wide_t'(ls1_reg) + sm;
        end
        y2_next = (2*N)'(qn + W_HALF_MAX);
    end

    // Stage 3: quotient estimate by M = 2^N - 1, low by at most one.
    always_comb
    begin
        est_sum = (2*N+1)'(y2_reg) + (2*N+1)'(y2_reg >> N);
        q3_next = est_sum[2*N:N];
    end

    // Stage 4: remainder check and correction of the estimate.
    always_comb
    begin
        rem = wide_t'(y3_reg) - (wide_t'(q3_reg) << N) + wide_t'(q3_reg);
        q4_next = q3_reg + (N+1)'(rem >= W_MAX);
    end

    // Stage 5: clamp the upper level and derive the lower one.
    always_comb
    begin
        two_l   = {info4_reg.light, 1'b0};
        q_clamp = q4_reg;
        if (q_clamp > two_l)
        begin
            q_clamp = two_l;
        end
        if (q_clamp > (N+1)'(hsl2rgb_pkg::CH_MAX))
        begin
            q_clamp = (N+1)'(hsl2rgb_pkg::CH_MAX);
        end
        p_raw = two_l - q_clamp;
        if (p_raw > q_clamp)
        begin
            p_raw = q_clamp;
        end
        lvl5_next.info = info4_reg;
        lvl5_next.qc   = q_clamp[N-1:0];
        lvl5_next.pc   = p_raw[N-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            info1_reg <= info1_next;
            sat1_reg  <= pix.saturation;
            low1_reg  <= low1_next;
            ls1_reg   <= ls1_next;
            info2_reg <= info1_reg;
            y2_reg    <= y2_next;
            info3_reg <= info2_reg;
            y3_reg    <= y2_reg;
            q3_reg    <= q3_next;
            info4_reg <= info3_reg;
            q4_reg    <= q4_next;
            lvl5_reg  <= lvl5_next;
        end
    end

    assign lvl_valid = valid_reg[4];
    assign lvl       = lvl5_reg;

endmodule

/* rtl/core/hsl2rgb_shade.sv */
// Two-stage channel unit that applies the piecewise-linear hue rule to one channel.
module hsl2rgb_shade
(
    input  logic                clk,
    input  logic                en,
    input  hsl2rgb_pkg::level_t lvl,
    input  hsl2rgb_pkg::pos_t   pos,
    output hsl2rgb_pkg::chan_t  color
);

    localparam int N = hsl2rgb_pkg::CH_BITS;

    typedef enum logic [1:0] {
        SEG_RISE,
        SEG_TOP,
        SEG_FALL,
        SEG_LOW
    } seg_t;

    localparam logic [2*N:0] ROUND_HALF = (2*N+1)'(hsl2rgb_pkg::TURN / 2);

    seg_t                seg_next;
    hsl2rgb_pkg::chan_t  w;
    logic [N:0]          twice_w;
    hsl2rgb_pkg::chan_t  diff;
    logic [2*N-1:0]      prod_next;

    seg_t                seg_reg;
    logic [2*N-1:0]      prod_reg;
    hsl2rgb_pkg::chan_t  pc_reg;
    hsl2rgb_pkg::chan_t  qc_reg;
    hsl2rgb_pkg::chan_t  light_reg;
    logic                grey_reg;

    logic [2*N:0]        rnd;
    logic [N+1:0]        ramp;
    hsl2rgb_pkg::chan_t  color_next;
    hsl2rgb_pkg::chan_t  color_reg;

    // Stage A: pick the segment and scale the level difference by the ramp.
    always_comb
    begin
        w = '0;
        if (pos < hsl2rgb_pkg::POS_HALF_TURN)
        begin
            seg_next = SEG_RISE;
            w        = pos[N-1:0];
        end
        else if (pos < hsl2rgb_pkg::POS_THREE_HALF)
        begin
            seg_next = SEG_TOP;
        end
        else if (pos < hsl2rgb_pkg::POS_TWO_TURN)
        begin
            seg_next = SEG_FALL;
            w        = N'(hsl2rgb_pkg::POS_TWO_TURN - pos);
        end
        else
        begin
            seg_next = SEG_LOW;
        end
        // The falling ramp can reach exactly half a turn, so the doubled ramp needs N+1 bits.
        twice_w   = {w, 1'b0};
        diff      = lvl.qc - lvl.pc;
        // The doubled ramp is at most one turn, so the product stays within 2N bits.
        prod_next = {{N{1'b0}}, diff} * {{(N-1){1'b0}}, twice_w};
    end

    // Stage B: round, add the lower level, clamp and select, or pass lightness through for grey.
    always_comb
    begin
        rnd  = (2*N+1)'(prod_reg) + ROUND_HALF;
        ramp = (N+2)'(pc_reg) + (N+2)'(rnd >> N);
        if (ramp > (N+2)'(hsl2rgb_pkg::CH_MAX))
        begin
            ramp = (N+2)'(hsl2rgb_pkg::CH_MAX);
        end
        case (seg_reg)
            SEG_RISE: color_next = ramp[N-1:0];
            SEG_FALL: color_next = ramp[N-1:0];
            SEG_TOP:  color_next = qc_reg;
            SEG_LOW:  color_next = pc_reg;
            default:  color_next = pc_reg;
        endcase
        if (grey_reg)
        begin
            color_next = light_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            seg_reg   <= seg_next;
            prod_reg  <= prod_next;
            pc_reg    <= lvl.pc;
            qc_reg    <= lvl.qc;
            light_reg <= lvl.info.light;
            grey_reg  <= lvl.info.grey;
            color_reg <= color_next;
        end
    end

    assign color = color_reg;

endmodule

/* rtl/core/hsl_to_rgb_converter.sv */
// Top level of the HSL to RGB color converter: pipeline control and channel units.
//
// Unless stalled, this block converts one color per clock from hue, saturation
// and lightness to red, green and blue. Hue is a fraction of a full turn
// (value / 2^16) and wraps; saturation, lightness and all three outputs are
// fractions of 65535. Zero saturation gives grey equal to lightness. Otherwise
// the upper and lower levels are formed with one 16x16 multiplier and an exact
// rounded division by 65535 (reciprocal estimate plus one correction), and each
// channel applies the piecewise-linear hue rule with its own 16x17 multiplier
// and half-up rounding. The pipeline has seven register stages, and a new
// request is taken on every cycle in which the output register is empty or
// being drained. The last stage is the output register. When the consumer
// raises rgb_stall with a result waiting, the whole pipeline holds in place
// and hsl_stall rises in the same cycle; nothing is dropped or repeated. There
// is no configuration and no state beyond the pipeline.
module hsl_to_rgb_converter
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              hsl_valid,
    output logic              hsl_stall,
    input  hsl2rgb_pkg::hsl_t hsl,
    output logic              rgb_valid,
    input  logic              rgb_stall,
    output hsl2rgb_pkg::rgb_t rgb
);

    logic                advance;
    logic                lvl_valid;
    hsl2rgb_pkg::level_t lvl;
    logic [1:0]          shade_valid_reg;

    // The pipeline moves as a whole whenever the output register can take a result.
    assign advance   = !shade_valid_reg[1] || !rgb_stall;
    assign hsl_stall = !advance;

    hsl2rgb_levels u_levels
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .pix_valid (hsl_valid),
        .pix       (hsl),
        .lvl_valid (lvl_valid),
        .lvl       (lvl)
    );

    // Valid bits for the two stages of the channel units.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shade_valid_reg <= '0;
        end
        else if (advance)
        begin
            shade_valid_reg <= {shade_valid_reg[0], lvl_valid};
        end
    end

    hsl2rgb_shade u_shade_red
    (
        .clk   (clk),
        .en    (advance),
        .lvl   (lvl),
        .pos   (lvl.info.pos[hsl2rgb_pkg::IDX_RED]),
        .color (rgb.red)
    );

    hsl2rgb_shade u_shade_green
    (
        .clk   (clk),
        .en    (advance),
        .lvl   (lvl),
        .pos   (lvl.info.pos[hsl2rgb_pkg::IDX_GREEN]),
        .color (rgb.green)
    );

    hsl2rgb_shade u_shade_blue
    (
        .clk   (clk),
        .en    (advance),
        .lvl   (lvl),
        .pos   (lvl.info.pos[hsl2rgb_pkg::IDX_BLUE]),
        .color (rgb.blue)
    );

    assign rgb_valid = shade_valid_reg[1];

    // The lower level never exceeds lightness, and lightness never exceeds the upper level.
    assert property (@(posedge clk) disable iff (!rst_n)
        lvl_valid |-> (lvl.pc <= lvl.info.light) && (lvl.info.light <= lvl.qc))
    else $error("level ordering broken");

    // A level result held back by a stall stays put until the pipeline moves.
    assert property (@(posedge clk) disable iff (!rst_n)
        lvl_valid && !advance |=> lvl_valid && $stable(lvl))
    else $error("level stage changed while stalled");

    // The input is only held off while a finished result waits at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        hsl_stall |-> rgb_valid && rgb_stall)
    else $error("input stalled with output free");

endmodule
